@@ rtl/gb3_pkg.sv @@
// shared types and constants for the 3x3 gaussian blur stream
package gb3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int PIX_W      = 16;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CFG_WIDTH_W  = COL_W + 1;
    localparam int CFG_HEIGHT_W = ROW_W + 1;
    localparam int CW_W       = PIX_W + 2;
    localparam int SUM_W      = PIX_W + 4;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = CFG_WIDTH_W'(1024);
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = CFG_HEIGHT_W'(1024);
    localparam logic [CFG_WIDTH_W-1:0]  MIN_WIDTH    = CFG_WIDTH_W'(3);
    localparam logic [CFG_HEIGHT_W-1:0] MIN_HEIGHT   = CFG_HEIGHT_W'(3);
    localparam logic [CFG_WIDTH_W-1:0]  MAX_WIDTH_V  = CFG_WIDTH_W'(MAX_WIDTH);
    localparam logic [CFG_HEIGHT_W-1:0] MAX_HEIGHT_V = CFG_HEIGHT_W'(MAX_HEIGHT);

    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] newer;
    } line_word_t;

    typedef struct packed
    {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row_m1;
        logic [COL_W-1:0] col_m1;
        logic             emit;
        logic             last;
    } pos_t;

    typedef struct packed
    {
        logic s1_valid;
        logic bypass;
    } fstat_t;

endpackage

@@ rtl/gb3_line_mem.sv @@
// two-row line buffer memory, one read and one write port, registered read
module gb3_line_mem
    import gb3_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    output line_word_t       rd_data,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_addr,
    input  line_word_t       wr_data
);

    line_word_t mem [MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/gb3_pos.sv @@
// frame position counters and interior pixel decode
module gb3_pos
    import gb3_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic                    frame_start,
    input  logic [CFG_WIDTH_W-1:0]  image_width,
    input  logic [CFG_HEIGHT_W-1:0] image_height,
    output pos_t                    cur
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] wm1;
    logic [ROW_W-1:0] hm1;
    logic [COL_W-1:0] c;
    logic [ROW_W-1:0] r;
    logic [CFG_WIDTH_W-1:0]  width_dec;
    logic [CFG_HEIGHT_W-1:0] height_dec;

    // clamp sizes to the supported range, keep size minus one
    always_comb
    begin
        width_dec  = image_width - CFG_WIDTH_W'(1);
        height_dec = image_height - CFG_HEIGHT_W'(1);
        if (image_width < MIN_WIDTH)
        begin
            wm1 = COL_W'(2);
        end
        else if (image_width > MAX_WIDTH_V)
        begin
            wm1 = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1 = width_dec[COL_W-1:0];
        end
        if (image_height < MIN_HEIGHT)
        begin
            hm1 = ROW_W'(2);
        end
        else if (image_height > MAX_HEIGHT_V)
        begin
            hm1 = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            hm1 = height_dec[ROW_W-1:0];
        end
    end

    always_comb
    begin
        c = frame_start ? '0 : col_reg;
        r = frame_start ? '0 : row_reg;
        cur.col    = c;
        cur.row_m1 = r - ROW_W'(1);
        cur.col_m1 = c - COL_W'(1);
        cur.emit   = (r >= ROW_W'(2)) && (c >= COL_W'(2)) && (r <= hm1) && (c <= wm1);
        cur.last   = (r == hm1) && (c == wm1);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (c >= wm1)
            begin
                col_next = '0;
                row_next = (r >= hm1) ? '0 : r + ROW_W'(1);
            end
            else
            begin
                col_next = c + COL_W'(1);
                row_next = r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

@@ rtl/gb3_filter.sv @@
// line buffer read-modify-write, column window, weighted sum and output register
module gb3_filter
    import gb3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    output logic             adv,
    input  pos_t             in_pos,
    input  logic [PIX_W-1:0] in_pixel,
    input  line_word_t       rd_data,
    output logic             wr_en,
    output logic [COL_W-1:0] wr_addr,
    output line_word_t       wr_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [SUM_W-1:0] blurred,
    output logic [ROW_W-1:0] out_row,
    output logic [COL_W-1:0] out_col,
    output logic             last,
    output fstat_t           stat
);

    logic             s1_valid_reg, s1_valid_next;
    pos_t             s1_pos_reg;
    logic [PIX_W-1:0] s1_px_reg;
    logic             s1_byp_reg;
    line_word_t       fwd_reg;
    logic [CW_W-1:0]  cw0_reg, cw1_reg;
    logic             out_valid_reg, out_valid_next;
    logic [SUM_W-1:0] blurred_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic             last_reg;
    line_word_t       cur_word;
    logic [CW_W-1:0]  cw_new;
    logic [SUM_W-1:0] sum;

    assign adv = !s1_valid_reg || !out_valid_reg || out_ready;

    // forward the word written at the edge this column was read
    assign cur_word = s1_byp_reg ? fwd_reg : rd_data;

    always_comb
    begin
        cw_new = CW_W'(cur_word.older) + {1'b0, cur_word.newer, 1'b0} + CW_W'(s1_px_reg);
        sum    = SUM_W'(cw0_reg) + {1'b0, cw1_reg, 1'b0} + SUM_W'(cw_new);
    end

    assign wr_en        = s1_valid_reg && adv;
    assign wr_addr      = s1_pos_reg.col;
    assign wr_data.older = cur_word.newer;
    assign wr_data.newer = s1_px_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (wr_en && s1_pos_reg.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_byp_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            cw0_reg       <= '0;
            cw1_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                s1_byp_reg <= wr_en && (wr_addr == in_pos.col);
            end
            if (wr_en)
            begin
                cw0_reg <= cw1_reg;
                cw1_reg <= cw_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg <= in_pos;
            s1_px_reg  <= in_pixel;
        end
        if (wr_en)
        begin
            fwd_reg <= wr_data;
        end
        if (wr_en && s1_pos_reg.emit)
        begin
            blurred_reg <= sum;
            out_row_reg <= s1_pos_reg.row_m1;
            out_col_reg <= s1_pos_reg.col_m1;
            last_reg    <= s1_pos_reg.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign blurred       = blurred_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign last          = last_reg;
    assign stat.s1_valid = s1_valid_reg;
    assign stat.bypass   = s1_byp_reg;

endmodule

@@ rtl/gaussian_blur_3x3_stream.sv @@
// top level of the 3x3 gaussian blur pixel stream
//
// pixels enter in raster order on the in_valid / in_ready channel, one word per
// pixel; frame_start on a word restarts the position counters at row 0, column 0.
// each interior pixel gives one word on out_valid / out_ready: the 1-2-1 by
// 1-2-1 weighted sum in units of 1/16, its row and column, and last on the
// final interior pixel of the frame. border rows and columns give no word.
// throughput is one pixel per cycle while out_ready is high or no word is held;
// the window sum is registered from the filter stage into the output register. the
// rate is set by the line buffer memory, read and written once per pixel at its column.
// image_width and image_height are written over the apb port at 0x0 and 0x4
// while the stream is idle; out of range sizes are clamped to 3..1024 and
// 3..4096. reset sets both sizes to 1024 and the counters to the frame origin;
// line buffer contents are not cleared and no clearing pass is needed.
// when out_ready is low the output register holds its word; one more pixel
// is taken into the pipeline, then in_ready drops until the word leaves.
module gaussian_blur_3x3_stream
    import gb3_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      pixel,
    input  logic                  frame_start,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SUM_W-1:0]      blurred,
    output logic [ROW_W-1:0]      out_row,
    output logic [COL_W-1:0]      out_col,
    output logic                  last
);

    logic [CFG_WIDTH_W-1:0]  width_reg, width_next;
    logic [CFG_HEIGHT_W-1:0] height_reg, height_next;
    reg_idx_t   reg_idx;
    logic       cfg_wr;
    logic       accept;
    logic       adv;
    pos_t       cur_pos;
    line_word_t rd_data;
    logic       wr_en;
    logic [COL_W-1:0] wr_addr;
    line_word_t wr_data;
    fstat_t     fstat;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        prdata      = '0;
        unique case (reg_idx)
            REG_IMAGE_WIDTH:
            begin
                prdata = APB_DATA_W'(width_reg);
                if (cfg_wr)
                begin
                    width_next = pwdata[CFG_WIDTH_W-1:0];
                end
            end
            REG_IMAGE_HEIGHT:
            begin
                prdata = APB_DATA_W'(height_reg);
                if (cfg_wr)
                begin
                    height_next = pwdata[CFG_HEIGHT_W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign in_ready = adv;
    assign accept   = in_valid && adv;

    gb3_pos u_pos
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .frame_start  (frame_start),
        .image_width  (width_reg),
        .image_height (height_reg),
        .cur          (cur_pos)
    );

    gb3_line_mem u_mem
    (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (cur_pos.col),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    gb3_filter u_filter
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .adv       (adv),
        .in_pos    (cur_pos),
        .in_pixel  (pixel),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .blurred   (blurred),
        .out_row   (out_row),
        .out_col   (out_col),
        .last      (last),
        .stat      (fstat)
    );

    // read of a column being written at the same edge must take the forwarded word
    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        accept && wr_en && (wr_addr == cur_pos.col) |=> fstat.bypass)
        else $error("line buffer hazard not forwarded");

    // an empty output register never blocks the input side
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with output register empty");

    // results belong to interior pixels only
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_row != '0) && (out_col != '0))
        else $error("result on a border pixel");

    // an accepted pixel occupies the filter stage on the next cycle
    a_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> fstat.s1_valid)
        else $error("accepted word lost");

endmodule

@@ tb/blur_scoreboard_pkg.sv @@
// scoreboard class that predicts blurred words from accepted pixels and checks them
`timescale 1ns / 1ps
package blur_scoreboard_pkg;

    import gb3_pkg::*;

    typedef struct packed
    {
        logic [SUM_W-1:0] blurred;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } blur_word_t;

    class blur_scoreboard;

        bit [CFG_WIDTH_W-1:0]  width_reg;
        bit [CFG_HEIGHT_W-1:0] height_reg;
        bit [PIX_W-1:0]        row_above [MAX_WIDTH];
        bit [PIX_W-1:0]        two_above [MAX_WIDTH];
        bit [PIX_W-1:0]        win_top [2];
        bit [PIX_W-1:0]        win_mid [2];
        bit [PIX_W-1:0]        win_bot [2];
        int unsigned           col_pos;
        int unsigned           row_pos;
        blur_word_t            pending_blur [$];
        int unsigned           words_checked;

        function new();
            width_reg     = WIDTH_RESET;
            height_reg    = HEIGHT_RESET;
            col_pos       = 0;
            row_pos       = 0;
            words_checked = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] data);
            case (idx)
                REG_IMAGE_WIDTH:  width_reg  = data[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg = data[CFG_HEIGHT_W-1:0];
                default:          ;
            endcase
        endfunction

        function int unsigned frame_width();
            if (width_reg < MIN_WIDTH)
                return MIN_WIDTH;
            if (width_reg > MAX_WIDTH_V)
                return MAX_WIDTH_V;
            return width_reg;
        endfunction

        function int unsigned frame_height();
            if (height_reg < MIN_HEIGHT)
                return MIN_HEIGHT;
            if (height_reg > MAX_HEIGHT_V)
                return MAX_HEIGHT_V;
            return height_reg;
        endfunction

        function int unsigned pending();
            return pending_blur.size();
        endfunction

        function void accept_pixel(logic [PIX_W-1:0] px, logic fs);
            int unsigned    w;
            int unsigned    h;
            int unsigned    r;
            int unsigned    c;
            int unsigned    sum;
            bit [PIX_W-1:0] top;
            bit [PIX_W-1:0] mid;
            blur_word_t     word;
            w = frame_width();
            h = frame_height();
            if (fs)
            begin
                col_pos = 0;
                row_pos = 0;
            end
            r   = row_pos;
            c   = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
            top = two_above[c];
            mid = row_above[c];
            if (r >= 2 && c >= 2 && r < h && c < w)
            begin
                sum = win_top[0] + 2 * win_mid[0] + win_bot[0]
                    + 2 * (win_top[1] + 2 * win_mid[1] + win_bot[1])
                    + top + 2 * mid + px;
                word.blurred = SUM_W'(sum);
                word.row     = ROW_W'(r - 1);
                word.col     = COL_W'(c - 1);
                word.last    = (r == h - 1) && (c == w - 1);
                pending_blur.push_back(word);
            end
            two_above[c] = mid;
            row_above[c] = px;
            win_top[0]   = win_top[1];
            win_mid[0]   = win_mid[1];
            win_bot[0]   = win_bot[1];
            win_top[1]   = top;
            win_mid[1]   = mid;
            win_bot[1]   = px;
            if (c >= w - 1)
            begin
                col_pos = 0;
                row_pos = (r >= h - 1) ? 0 : r + 1;
            end
            else
            begin
                col_pos = c + 1;
            end
        endfunction

        function string check_word(blur_word_t got);
            blur_word_t want;
            string      diff;
            if (pending_blur.size() == 0)
                return $sformatf("unexpected word: blurred %0d row %0d col %0d last %0b",
                                 got.blurred, got.row, got.col, got.last);
            want = pending_blur.pop_front();
            words_checked++;
            diff = "";
            if (got.blurred !== want.blurred)
                diff = {diff, $sformatf(" blurred %0d want %0d", got.blurred, want.blurred)};
            if (got.row !== want.row)
                diff = {diff, $sformatf(" row %0d want %0d", got.row, want.row)};
            if (got.col !== want.col)
                diff = {diff, $sformatf(" col %0d want %0d", got.col, want.col)};
            if (got.last !== want.last)
                diff = {diff, $sformatf(" last %0b want %0b", got.last, want.last)};
            if (diff == "")
                return "";
            return $sformatf("word for row %0d col %0d:%s", want.row, want.col, diff);
        endfunction

    endclass

endpackage

@@ tb/gaussian_blur_3x3_stream_tb.sv @@
// top level testbench of the 3x3 gaussian blur stream: stimulus, handshakes and checking
`timescale 1ns / 1ps
module gaussian_blur_3x3_stream_tb;

    import gb3_pkg::*;
    import blur_scoreboard_pkg::*;

    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned IDLE_CYCLES   = 8;
    localparam int unsigned RANDOM_PIXELS = 150;
    localparam int unsigned DRAIN_LIMIT   = 5000;
    localparam int unsigned MAX_REPORTS   = 40;
    localparam int unsigned RUN_LIMIT_NS  = 10_000_000;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [PIX_W-1:0]      pixel       = '0;
    logic                  frame_start = 1'b0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [SUM_W-1:0]      blurred;
    logic [ROW_W-1:0]      out_row;
    logic [COL_W-1:0]      out_col;
    logic                  last;

    blur_scoreboard sb;
    int unsigned    errors         = 0;
    int unsigned    pixels_in      = 0;
    int unsigned    settings_done  = 0;
    int unsigned    holds_done     = 0;
    int unsigned    burst_left     = 0;
    bit             hold_req       = 1'b0;

    gaussian_blur_3x3_stream DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel       (pixel),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .blurred     (blurred),
        .out_row     (out_row),
        .out_col     (out_col),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [APB_DATA_W-1:0] width_word,
                             input logic [APB_DATA_W-1:0] height_word);
        wait_idle();
        apb_write(REG_IMAGE_WIDTH, width_word);
        apb_write(REG_IMAGE_HEIGHT, height_word);
        settings_done++;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
        in_valid    <= 1'b1;
        pixel       <= px;
        frame_start <= fs;
        do
            @(posedge clk);
        while (!in_ready);
        sb.accept_pixel(px, fs);
        pixels_in++;
    endtask

    task automatic sender_pause();
        int unsigned gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic run_stream(input int unsigned n, input logic first_fs,
                              input int unsigned noise_permille);
        logic fs;
        for (int unsigned i = 0; i < n; i++)
        begin
            fs = (i == 0) ? first_fs : ($urandom_range(0, 999) < noise_permille);
            send_pixel(PIX_W'($urandom()), fs);
            sender_pause();
        end
    endtask

    function automatic logic [APB_DATA_W-1:0] size_word(input int unsigned raw,
                                                         input logic [APB_DATA_W-1:0] keep);
        return (APB_DATA_W'($urandom()) & ~keep) | APB_DATA_W'(raw);
    endfunction

    // receiver: checks words and stalls on its own pattern
    initial
    begin
        int unsigned tick;
        int unsigned mode;
        int unsigned hold_left;
        logic [7:0]  mask;
        blur_word_t  got;
        string       msg;
        tick      = 0;
        mode      = 0;
        hold_left = 0;
        mask      = '1;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.blurred = blurred;
                got.row     = out_row;
                got.col     = out_col;
                got.last    = last;
                msg = sb.check_word(got);
                if (msg != "")
                    report_mismatch(msg);
            end
            if (tick % 64 == 0)
            begin
                mode = $urandom_range(0, 3);
                mask = 8'($urandom());
            end
            tick++;
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                holds_done++;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= mask[tick % 8];
                    2:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned n;
        int unsigned noise;
        int unsigned old_w;
        int unsigned random_pixels;
        int unsigned drain;
        logic        first_fs;
        logic        fs;
        logic [PIX_W-1:0] px;
        sb            = new();
        random_pixels = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest frame: saturated, then zeros, then a restart mid-frame
        configure(32'd2, 32'd0);
        for (int unsigned i = 0; i < 23; i++)
        begin
            if (i < 9)
            begin
                px = '1;
                fs = (i == 0);
            end
            else if (i < 14)
            begin
                px = '0;
                fs = 1'b0;
            end
            else
            begin
                px = i[0] ? 16'hAAAA : 16'h5555;
                fs = (i == 14);
            end
            send_pixel(px, fs);
            sender_pause();
        end

        for (phase = 0; phase < 7 || random_pixels < RANDOM_PIXELS; phase++)
        begin
            old_w = sb.frame_width();
            case (phase)
                1:
                begin
                    configure(32'hFFFF_FFFF, 32'd3);
                    n     = MAX_WIDTH + 8;
                    noise = 0;
                end
                3:
                begin
                    configure(32'd3, 32'hFFFF_FFFF);
                    n        = 150;
                    noise    = 0;
                    hold_req = 1'b1;
                end
                5:
                begin
                    configure(32'(MAX_WIDTH), 32'(MAX_HEIGHT));
                    n     = 40;
                    noise = 0;
                end
                default:
                begin
                    configure(size_word(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2)
                                                                    : $urandom_range(3, 24),
                                        32'h0000_07FF),
                              size_word(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2)
                                                                    : $urandom_range(3, 10),
                                        32'h0000_1FFF));
                    n     = $urandom_range(sb.frame_width() * sb.frame_height() / 2,
                                           3 * sb.frame_width() * sb.frame_height() / 2);
                    noise = 15;
                    random_pixels += n;
                    if (phase == 4)
                        hold_req = 1'b1;
                end
            endcase
            // a frame that grows in width starts over so the line buffers refill
            if (sb.frame_width() > old_w)
                first_fs = 1'b1;
            else if (phase == 6)
                first_fs = 1'b0;
            else
                first_fs = 1'($urandom_range(0, 1));
            run_stream(n, first_fs, noise);
        end

        in_valid <= 1'b0;
        drain = 0;
        while (sb.pending() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (IDLE_CYCLES + 2) @(posedge clk);
        if (sb.pending() != 0)
            report_mismatch($sformatf("%0d expected words never arrived", sb.pending()));

        $display("%0d pixels sent, %0d blurred words checked, %0d size settings",
                 pixels_in, sb.words_checked, settings_done);
        $display("sizes clamped at both ends up to 1024 wide and 4096 tall, %0d long output holds",
                 holds_done);
        if (errors == 0)
            $display("gaussian_blur_3x3_stream_tb: done, clean");
        else
            $display("gaussian_blur_3x3_stream_tb: done, errors");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("gaussian_blur_3x3_stream_tb: done, errors");
        $finish;
    end

endmodule
